### rtl/core/lsds_pkg.sv
`timescale 1ns / 1ps

package lsds_pkg;

    // Field and register widths
    localparam int RANGE_W   = 16;
    localparam int ENTRY_W   = RANGE_W + 1;   // bit 16 no_return, bits 15..0 range
    localparam int THR_W     = 16;
    localparam int SW_W      = 9;
    localparam int MIN_W     = 11;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIR_W     = 2;
    localparam int CNT_W     = SW_W;          // finite samples in one sector
    localparam int SUM_W     = SW_W + RANGE_W; // sector sum, any 9-bit width

    // Scan length field of a job, wide enough for the largest buffer
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int JOB_LEN_W       = 13;

    // Register reset values
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(350);
    localparam logic [SW_W-1:0]  SW_RESET  = SW_W'(110);
    localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(330);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES     = 2'd2;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT   = 2'd2;
    localparam logic [DIR_W-1:0] DIR_UNKNOWN = 2'd3;

    // One finished scan handed from front to back
    typedef struct packed {
        logic [JOB_LEN_W-1:0] len;
        logic                 short_scan;
    } job_t;

    // Back-end status seen by the front and the top level
    typedef struct packed {
        logic sweeping;   // buffer is being read
        logic buf_free;   // buffer walk ends this cycle, no more reads
    } back_stat_t;

endpackage

### rtl/core/lsds_buf.sv
`timescale 1ns / 1ps

module lsds_buf #(
    parameter int DEPTH = lsds_pkg::MAX_SAMPLES_DEF,
    parameter int AW    = $clog2(lsds_pkg::MAX_SAMPLES_DEF)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [lsds_pkg::ENTRY_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [lsds_pkg::ENTRY_W-1:0] rdata
);
    import lsds_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/lsds_queue.sv
`timescale 1ns / 1ps

module lsds_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lsds_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output lsds_pkg::job_t head
);
    import lsds_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign full  = fill_reg[1];
    assign valid = (fill_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

endmodule

### rtl/core/lsds_front.sv
`timescale 1ns / 1ps

module lsds_front #(
    parameter int MAX_SAMPLES = lsds_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsds_pkg::RANGE_W-1:0]  range_mm,
    input  logic                          no_return,
    input  logic                          s_tlast,
    input  logic [lsds_pkg::MIN_W-1:0]    min_samples,
    input  lsds_pkg::back_stat_t          bstat,
    input  logic                          q_full,
    output logic                          q_push,
    output lsds_pkg::job_t                q_job,
    output logic                          buf_we,
    output logic [$clog2(MAX_SAMPLES)-1:0] buf_waddr,
    output logic [lsds_pkg::ENTRY_W-1:0]  buf_wdata
);
    import lsds_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int LW = $clog2(MAX_SAMPLES + 1);
    localparam int CW = (LW > MIN_W) ? LW : MIN_W;

    logic [LW-1:0] count_reg, count_next;
    logic          hold_reg, hold_next;
    logic          accept;
    logic          room;
    logic [LW-1:0] scan_len;
    logic          short_scan;

    // Stall while the back still reads the buffer or no job slot is free
    assign s_tready = !hold_reg && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign room     = (count_reg < LW'(MAX_SAMPLES));

    // Store the sample while the buffer has room
    assign buf_we    = accept && room;
    assign buf_waddr = count_reg[AW-1:0];
    assign buf_wdata = {no_return, range_mm};

    // Classify the scan on its last sample
    assign scan_len   = room ? count_reg + LW'(1) : count_reg;
    assign short_scan = (CW'(scan_len) < CW'(min_samples));
    assign q_push     = accept && s_tlast;
    assign q_job.len        = JOB_LEN_W'(scan_len);
    assign q_job.short_scan = short_scan;

    always_comb begin
        count_next = count_reg;
        hold_next  = hold_reg;
        if (accept) begin
            if (s_tlast) begin
                count_next = '0;
            end else if (room) begin
                count_next = count_reg + LW'(1);
            end
        end
        // Hold the buffer for a full scan until the back end frees it
        if (q_push && !short_scan) begin
            hold_next = 1'b1;
        end else if (bstat.buf_free) begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            hold_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

### rtl/core/lsds_back.sv
`timescale 1ns / 1ps

module lsds_back #(
    parameter int MAX_SAMPLES = lsds_pkg::MAX_SAMPLES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lsds_pkg::THR_W-1:0]     front_threshold_mm,
    input  logic [lsds_pkg::SW_W-1:0]      sector_width,
    input  logic                           q_valid,
    input  lsds_pkg::job_t                 q_head,
    output logic                           q_pop,
    output logic                           buf_re,
    output logic [$clog2(MAX_SAMPLES)-1:0] buf_raddr,
    input  logic [lsds_pkg::ENTRY_W-1:0]   buf_rdata,
    output lsds_pkg::back_stat_t           bstat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lsds_pkg::DIR_W-1:0]     direction,
    output logic [lsds_pkg::RANGE_W-1:0]   avg_left_mm,
    output logic [lsds_pkg::RANGE_W-1:0]   avg_front_mm,
    output logic [lsds_pkg::RANGE_W-1:0]   avg_right_mm
);
    import lsds_pkg::*;

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int LW   = $clog2(MAX_SAMPLES + 1);
    localparam int PW   = ((LW > SW_W + 1) ? LW : SW_W + 1) + 2;
    localparam int STW  = $clog2(SUM_W);
    localparam int REM_W = CNT_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SWEEP  = 5'b00010,
        ST_DIVLD  = 5'b00100,
        ST_DIVRUN = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           k_reg, k_next;
    logic [LW-1:0]        len_reg, len_next;
    logic                 short_reg, short_next;
    logic [PW-1:0]        start_reg, start_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [SW_W-1:0]      j_reg, j_next;
    logic                 rd_v_reg;
    logic [1:0]           rd_tag_reg;
    logic [SUM_W-1:0]     sum_reg [3];
    logic [CNT_W-1:0]     cnt_reg [3];
    logic [SUM_W-1:0]     dvd_reg, dvd_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [STW-1:0]       step_reg, step_next;
    logic [RANGE_W-1:0]   avg_reg [3];
    logic                 out_valid_reg, out_valid_next;
    logic [DIR_W-1:0]     out_dir_reg;
    logic [RANGE_W-1:0]   out_l_reg, out_f_reg, out_r_reg;

    logic                 clear_acc;
    logic                 sector_end;
    logic                 issue;
    logic [PW-1:0]        next_start;
    logic [PW-1:0]        first_start;
    logic [REM_W:0]       trial;
    logic                 ge;
    logic [SUM_W-1:0]     quot;
    logic                 avg_we;
    logic [RANGE_W-1:0]   avg_val;
    logic                 out_load;
    logic [DIR_W-1:0]     dir_pick;

    // Sector walk: stop at the sector width or at the end of the scan
    assign sector_end  = (j_reg == sector_width) || (pos_reg >= PW'(len_reg));
    assign issue       = (state_reg == ST_SWEEP) && !sector_end;
    assign next_start  = start_reg + PW'(sector_width) + PW'(1);
    assign first_start = PW'(q_head.len[LW-1:2]);
    assign buf_re      = issue;
    assign buf_raddr   = pos_reg[AW-1:0];

    // One restoring division step
    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign ge    = (trial >= {1'b0, cnt_reg[k_reg]});
    assign quot  = {dvd_reg[SUM_W-2:0], ge};

    // Direction choice; ties go right, then forward, then left
    always_comb begin
        if (short_reg) begin
            dir_pick = DIR_UNKNOWN;
        end else if (avg_reg[1] <= front_threshold_mm) begin
            if (avg_reg[0] >= avg_reg[1] && avg_reg[0] >= avg_reg[2]) begin
                dir_pick = DIR_RIGHT;
            end else if (avg_reg[1] >= avg_reg[2] && avg_reg[1] >= avg_reg[0]) begin
                dir_pick = DIR_FORWARD;
            end else begin
                dir_pick = DIR_LEFT;
            end
        end else begin
            dir_pick = DIR_FORWARD;
        end
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        short_next     = short_reg;
        start_next     = start_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        q_pop          = 1'b0;
        clear_acc      = 1'b0;
        avg_we         = 1'b0;
        avg_val        = '0;
        bstat.buf_free = 1'b0;
        bstat.sweeping = (state_reg == ST_SWEEP);
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    clear_acc  = 1'b1;
                    len_next   = q_head.len[LW-1:0];
                    short_next = q_head.short_scan;
                    start_next = first_start;
                    pos_next   = first_start;
                    j_next     = '0;
                    k_next     = 2'd0;
                    state_next = q_head.short_scan ? ST_OUT : ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sector_end) begin
                    if (k_reg == 2'd2) begin
                        bstat.buf_free = 1'b1;
                        k_next         = 2'd0;
                        state_next     = ST_DIVLD;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        start_next = next_start;
                        pos_next   = next_start;
                        j_next     = '0;
                    end
                end else begin
                    pos_next = pos_reg + PW'(1);
                    j_next   = j_reg + SW_W'(1);
                end
            end
            ST_DIVLD: begin
                if (cnt_reg[k_reg] == '0) begin
                    avg_we  = 1'b1;
                    avg_val = '0;
                    if (k_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end else begin
                        k_next = k_reg + 2'd1;
                    end
                end else begin
                    dvd_next   = sum_reg[k_reg];
                    rem_next   = '0;
                    step_next  = STW'(SUM_W - 1);
                    state_next = ST_DIVRUN;
                end
            end
            ST_DIVRUN: begin
                rem_next  = ge ? REM_W'(trial - {1'b0, cnt_reg[k_reg]}) : trial[REM_W-1:0];
                dvd_next  = quot;
                step_next = step_reg - STW'(1);
                if (step_reg == '0) begin
                    avg_we  = 1'b1;
                    avg_val = quot[RANGE_W-1:0];
                    if (k_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_DIVLD;
                    end
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rd_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        len_reg    <= len_next;
        short_reg  <= short_next;
        start_reg  <= start_next;
        pos_reg    <= pos_next;
        j_reg      <= j_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        rd_tag_reg <= k_reg;
    end

    // Accumulate finite samples in the cycle after their read
    always_ff @(posedge aclk) begin
        if (clear_acc) begin
            for (int s = 0; s < 3; s++) begin
                sum_reg[s] <= '0;
                cnt_reg[s] <= '0;
            end
        end else if (rd_v_reg && !buf_rdata[RANGE_W]) begin
            sum_reg[rd_tag_reg] <= sum_reg[rd_tag_reg] + SUM_W'(buf_rdata[RANGE_W-1:0]);
            cnt_reg[rd_tag_reg] <= cnt_reg[rd_tag_reg] + CNT_W'(1);
        end
    end

    // Sector averages; a short scan reports zeros
    always_ff @(posedge aclk) begin
        if (clear_acc) begin
            for (int s = 0; s < 3; s++) begin
                avg_reg[s] <= '0;
            end
        end else if (avg_we) begin
            avg_reg[k_reg] <= avg_val;
        end
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_dir_reg <= dir_pick;
            out_r_reg   <= avg_reg[0];
            out_f_reg   <= avg_reg[1];
            out_l_reg   <= avg_reg[2];
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign direction    = out_dir_reg;
    assign avg_left_mm  = out_l_reg;
    assign avg_front_mm = out_f_reg;
    assign avg_right_mm = out_r_reg;

endmodule

### rtl/core/lidar_sector_direction_select.sv
`timescale 1ns / 1ps

// Lidar sector direction selector.
// The slave channel takes one range sample per item; s_tlast marks the final
// sample of a scan. The master channel gives one result per scan: the chosen
// direction and the mean range of the left, front and right sectors.
// Samples are taken at one per cycle while s_tready is high. After the last
// sample of a scan long enough to judge, the back end walks the buffer,
// one memory read a cycle, then runs a bit-serial divider on each non-empty
// sector and loads the output register. A short scan skips the walk and
// the divider and goes straight to the output register.
// The next scan may start loading as soon as the buffer walk is done; until
// then s_tready stays low. A job queue of two scans sits between loader
// and back end, so loading carries on while a result waits to be taken.
// When the receiver stalls, the result holds in the output register and
// the back end waits; once the queue is full, s_tready drops.
// Reset clears the control state and reloads the register defaults; the
// buffer needs no clearing pass. Configuration is written on cfg_we.
module lidar_sector_direction_select #(
    parameter int MAX_SAMPLES = lsds_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // range_mm
    input  logic [0:0]                       s_tuser,   // no_return
    input  logic                             s_tlast,   // last_sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [47:0]                      m_tdata,   // avg_right_mm, avg_front_mm, avg_left_mm
    output logic [lsds_pkg::DIR_W-1:0]       m_tuser,   // direction
    input  logic                             cfg_we,
    input  logic [lsds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsds_pkg::CFG_W-1:0]       cfg_data
);
    import lsds_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);

    logic [THR_W-1:0]   thr_reg;
    logic [SW_W-1:0]    sw_reg;
    logic [MIN_W-1:0]   min_reg;

    back_stat_t         bstat;
    logic               q_push, q_full, q_pop, q_valid;
    job_t               q_job, q_head;
    logic               buf_we, buf_re;
    logic [AW-1:0]      buf_waddr, buf_raddr;
    logic [ENTRY_W-1:0] buf_wdata, buf_rdata;
    logic [RANGE_W-1:0] avg_l, avg_f, avg_r;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
            sw_reg  <= SW_RESET;
            min_reg <= MIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRONT_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                CFG_SECTOR_WIDTH:    sw_reg  <= cfg_data[SW_W-1:0];
                CFG_MIN_SAMPLES:     min_reg <= cfg_data[MIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lsds_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .range_mm    (s_tdata),
        .no_return   (s_tuser[0]),
        .s_tlast     (s_tlast),
        .min_samples (min_reg),
        .bstat       (bstat),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_job),
        .buf_we      (buf_we),
        .buf_waddr   (buf_waddr),
        .buf_wdata   (buf_wdata)
    );

    lsds_buf #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    lsds_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    lsds_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .front_threshold_mm (thr_reg),
        .sector_width       (sw_reg),
        .q_valid            (q_valid),
        .q_head             (q_head),
        .q_pop              (q_pop),
        .buf_re             (buf_re),
        .buf_raddr          (buf_raddr),
        .buf_rdata          (buf_rdata),
        .bstat              (bstat),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .direction          (m_tuser),
        .avg_left_mm        (avg_l),
        .avg_front_mm       (avg_f),
        .avg_right_mm       (avg_r)
    );

    assign m_tdata = {avg_r, avg_f, avg_l};

    // The loader never overwrites the buffer while the back end walks it
    a_no_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_we |-> !bstat.sweeping)
        else $error("buffer written during sector walk");

    // A scan job is never pushed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job queue overflow");

    // Freeing the buffer ends the walk
    a_free_ends_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        bstat.buf_free |=> !bstat.sweeping)
        else $error("sector walk continues after buffer release");

    // An unknown result carries zero averages
    a_unknown_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == DIR_UNKNOWN)) |-> (m_tdata == '0))
        else $error("unknown direction with non-zero averages");

endmodule
